[hw/rtl/dfpr_pkg.sv]
`timescale 1ns / 1ps

package dfpr_pkg;

    // Parser phase of the field that is being read, one-hot.
    typedef enum logic [5:0] {
        PH_LEAD   = 6'b000001,
        PH_SIGNED = 6'b000010,
        PH_INT    = 6'b000100,
        PH_FRAC   = 6'b001000,
        PH_DONE   = 6'b010000,
        PH_BAD    = 6'b100000
    } phase_t;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLOSE = 5'b00010,
        S_QWALK = 5'b00100,
        S_QDIV  = 5'b01000,
        S_QOUT  = 5'b10000
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // a request is accepted this cycle
        logic clear;       // drop all per-response state
        logic set_ended;   // mark the content as ended
        logic close;       // close the current field
        logic more;        // further closes follow this one
        logic walk;        // one step of the ring walk
        logic qdiv;        // form the margin product
        logic qout;        // load the range report
    } dfpr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_op;          // input request is a range query
        logic in_final;       // input request is the last byte
        logic ended;          // content of this response has ended
        logic end_cond;       // input byte ends the content
        logic is_pipe;        // input byte is a field separator
        logic cur_lt_active;  // current field belongs to a sensor in use
        logic out_free;       // output register can be loaded
        logic walk_done;      // ring walk has seen every entry
    } dfpr_st_t;

    localparam logic [7:0]  CHAR_PIPE  = 8'h7C;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [7:0]  CHAR_DOT   = 8'h2E;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [28:0] INT_LIMIT  = 29'd20000000;
    localparam logic [31:0] CENTI      = 32'd100;
    localparam logic [31:0] FLAT_MARGIN = 32'd100;
    // ceil(2^34 / 5): x / 5 == (x * RECIP_FIVE) >> 34 for any 32-bit x.
    localparam logic [31:0] RECIP_FIVE = 32'hCCCCCCCD;
    localparam logic [3:0]  CFG_RESET  = 4'd8;

endpackage

[hw/rtl/dfpr_ram.sv]
`timescale 1ns / 1ps

module dfpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/dfpr_ctrl.sv]
`timescale 1ns / 1ps

module dfpr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dfpr_pkg::dfpr_st_t  st,
    output dfpr_pkg::dfpr_cmd_t cmd
);

    import dfpr_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [1:0]  forced_reg, forced_next;
    logic        loop_reg, loop_next;
    logic        fin_reg, fin_next;
    logic        do_close;

    // A close is still owed while forced closes remain, or while the
    // end-of-content sweep has sensors left.
    assign do_close = (forced_reg != 2'd0) || (loop_reg && st.cur_lt_active);

    always_comb
    begin
        state_next  = state_reg;
        forced_next = forced_reg;
        loop_next   = loop_reg;
        fin_next    = fin_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take = 1'b1;
                    fin_next = st.in_final;
                    if (st.in_op)
                    begin
                        state_next = S_QWALK;
                    end
                    else if (st.ended)
                    begin
                        cmd.clear = st.in_final;
                    end
                    else if (st.end_cond)
                    begin
                        forced_next = 2'd1;
                        loop_next   = 1'b1;
                        state_next  = S_CLOSE;
                    end
                    else if (st.is_pipe)
                    begin
                        forced_next = st.in_final ? 2'd2 : 2'd1;
                        loop_next   = st.in_final;
                        state_next  = S_CLOSE;
                    end
                    else if (st.in_final)
                    begin
                        forced_next = 2'd1;
                        loop_next   = 1'b1;
                        state_next  = S_CLOSE;
                    end
                end
            end
            S_CLOSE:
            begin
                if (do_close)
                begin
                    if (!st.cur_lt_active || st.out_free)
                    begin
                        cmd.close   = 1'b1;
                        forced_next = (forced_reg == 2'd0) ? 2'd0 : forced_reg - 2'd1;
                        cmd.more    = (forced_next != 2'd0) || loop_reg;
                    end
                end
                else
                begin
                    cmd.set_ended = loop_reg;
                    cmd.clear     = fin_reg;
                    state_next    = S_IDLE;
                end
            end
            S_QWALK:
            begin
                cmd.walk = 1'b1;
                if (st.walk_done)
                begin
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                cmd.qdiv   = 1'b1;
                state_next = S_QOUT;
            end
            S_QOUT:
            begin
                if (st.out_free)
                begin
                    cmd.qout   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            forced_reg <= 2'd0;
            loop_reg   <= 1'b0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            forced_reg <= forced_next;
            loop_reg   <= loop_next;
            fin_reg    <= fin_next;
        end
    end

    a_close_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close && st.cur_lt_active |-> st.out_free)
        else $error("field report loaded while output register is busy");

    a_query_walks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && s_tvalid && st.in_op |=> state_reg == S_QWALK)
        else $error("range query did not start a ring walk");

    a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_QDIV |=> state_reg == S_QOUT)
        else $error("margin step not followed by range report");

endmodule

[hw/rtl/dfpr_dp.sv]
`timescale 1ns / 1ps

module dfpr_dp #(
    parameter int MAX_SENSORS    = 8,
    parameter int RING_POINTS    = 64,
    parameter int RESPONSE_BYTES = 1024,
    parameter int FIELD_CHARS    = 39
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    input  logic                cfg_valid,
    input  logic [3:0]          cfg_data,
    input  dfpr_pkg::dfpr_cmd_t cmd,
    output dfpr_pkg::dfpr_st_t  st,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [103:0]        m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    import dfpr_pkg::*;

    localparam int CW  = $clog2(MAX_SENSORS + 1);
    localparam int SW  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int HW  = $clog2(RING_POINTS);
    localparam int FW  = $clog2(RING_POINTS + 1);
    localparam int BW  = $clog2(RESPONSE_BYTES);
    localparam int FCW = $clog2(FIELD_CHARS + 1);
    localparam int DEPTH = MAX_SENSORS * RING_POINTS;
    localparam int AW  = $clog2(DEPTH);

    logic [7:0] in_char;
    logic [2:0] in_qs;
    assign in_char = s_tdata[7:0];
    assign in_qs   = s_tdata[10:8];

    logic [3:0]     cfg_reg;
    phase_t         phase_reg, phase_next;
    logic           neg_reg, neg_next;
    logic [24:0]    int_reg, int_next;
    logic [6:0]     frac_reg, frac_next;
    logic [1:0]     fdig_reg, fdig_next;
    logic [FCW-1:0] fchars_reg, fchars_next;
    logic [CW-1:0]  cur_reg, cur_next;
    logic [CW-1:0]  good_reg, good_next;
    logic           ended_reg, ended_next;
    logic [BW-1:0]  bytes_reg, bytes_next;
    logic [HW-1:0]  head_reg [MAX_SENSORS];
    logic [FW-1:0]  fill_reg [MAX_SENSORS];

    logic [CW-1:0] active;
    logic [SW-1:0] cur_i;
    logic          byte_go;
    logic          feed_go;
    logic          is_digit;
    logic [3:0]    digit;
    logic [28:0]   int_x10;

    assign active = (5'(cfg_reg) > 5'(MAX_SENSORS)) ? CW'(MAX_SENSORS) : CW'(cfg_reg);
    assign cur_i  = cur_reg[SW-1:0];
    assign is_digit = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
    assign digit    = 4'(in_char - CHAR_ZERO);
    assign int_x10  = {int_reg, 3'b000} + {3'b000, int_reg, 1'b0} + 29'(digit);

    assign st.in_op         = s_tuser;
    assign st.in_final      = s_tlast;
    assign st.ended         = ended_reg;
    assign st.end_cond      = (in_char == 8'd0) || (bytes_reg >= BW'(RESPONSE_BYTES - 1));
    assign st.is_pipe       = (in_char == CHAR_PIPE);
    assign st.cur_lt_active = (cur_reg < active);

    assign byte_go = cmd.take && !s_tuser && !ended_reg && !st.end_cond;
    assign feed_go = byte_go && !st.is_pipe && st.cur_lt_active
                     && (fchars_reg < FCW'(FIELD_CHARS));

    // Value of the field being closed.
    logic        field_ok;
    logic [6:0]  frac_adj;
    logic [31:0] mag;
    logic [31:0] val;
    logic [CW-1:0] good_inc;

    assign field_ok = (phase_reg == PH_INT) || (phase_reg == PH_FRAC) || (phase_reg == PH_DONE);
    assign frac_adj = (fdig_reg == 2'd1) ? 7'({frac_reg, 3'b000} + {frac_reg, 1'b0}) : frac_reg;
    assign mag      = 32'(32'(int_reg) * CENTI) + 32'(frac_adj);
    assign val      = neg_reg ? (32'd0 - mag) : mag;
    assign good_inc = good_reg + CW'(1);

    logic ring_we;
    assign ring_we = cmd.close && st.cur_lt_active && field_ok;

    always_comb
    begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        int_next    = int_reg;
        frac_next   = frac_reg;
        fdig_next   = fdig_reg;
        fchars_next = fchars_reg;
        cur_next    = cur_reg;
        good_next   = good_reg;
        ended_next  = ended_reg;
        bytes_next  = bytes_reg;
        if (byte_go)
        begin
            bytes_next = bytes_reg + BW'(1);
        end
        if (feed_go)
        begin
            fchars_next = fchars_reg + FCW'(1);
            unique case (phase_reg)
                PH_LEAD:
                begin
                    priority if (in_char == CHAR_SPACE)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if (in_char == CHAR_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGNED;
                    end
                    else if (in_char == CHAR_PLUS)
                    begin
                        phase_next = PH_SIGNED;
                    end
                    else if (is_digit)
                    begin
                        int_next   = 25'(digit);
                        phase_next = PH_INT;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_SIGNED:
                begin
                    if (is_digit)
                    begin
                        int_next   = 25'(digit);
                        phase_next = PH_INT;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_INT:
                begin
                    priority if (is_digit)
                    begin
                        if (int_x10 > INT_LIMIT)
                        begin
                            phase_next = PH_BAD;
                        end
                        else
                        begin
                            int_next = int_x10[24:0];
                        end
                    end
                    else if (in_char == CHAR_DOT)
                    begin
                        phase_next = PH_FRAC;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_FRAC:
                begin
                    if (is_digit)
                    begin
                        frac_next = 7'({frac_reg, 3'b000} + {frac_reg, 1'b0}) + 7'(digit);
                        fdig_next = fdig_reg + 2'd1;
                        if (fdig_next >= 2'd2)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        if (cmd.close)
        begin
            if (ring_we)
            begin
                good_next = good_inc;
            end
            if (cur_reg < CW'(MAX_SENSORS))
            begin
                cur_next = cur_reg + CW'(1);
            end
            phase_next  = PH_LEAD;
            neg_next    = 1'b0;
            int_next    = '0;
            frac_next   = '0;
            fdig_next   = '0;
            fchars_next = '0;
        end
        if (cmd.set_ended)
        begin
            ended_next = 1'b1;
        end
        if (cmd.clear)
        begin
            phase_next  = PH_LEAD;
            neg_next    = 1'b0;
            int_next    = '0;
            frac_next   = '0;
            fdig_next   = '0;
            fchars_next = '0;
            cur_next    = '0;
            good_next   = '0;
            ended_next  = 1'b0;
            bytes_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= CFG_RESET;
            phase_reg  <= PH_LEAD;
            neg_reg    <= 1'b0;
            int_reg    <= '0;
            frac_reg   <= '0;
            fdig_reg   <= '0;
            fchars_reg <= '0;
            cur_reg    <= '0;
            good_reg   <= '0;
            ended_reg  <= 1'b0;
            bytes_reg  <= '0;
            for (int i = 0; i < MAX_SENSORS; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            int_reg    <= int_next;
            frac_reg   <= frac_next;
            fdig_reg   <= fdig_next;
            fchars_reg <= fchars_next;
            cur_reg    <= cur_next;
            good_reg   <= good_next;
            ended_reg  <= ended_next;
            bytes_reg  <= bytes_next;
            if (ring_we)
            begin
                head_reg[cur_i] <= (head_reg[cur_i] == HW'(RING_POINTS - 1))
                                   ? '0 : head_reg[cur_i] + HW'(1);
                if (fill_reg[cur_i] < FW'(RING_POINTS))
                begin
                    fill_reg[cur_i] <= fill_reg[cur_i] + FW'(1);
                end
            end
        end
    end

    // Ring walk for a range query.
    logic [SW-1:0] qs_reg;
    logic [2:0]    qid_reg;
    logic [FW-1:0] qfill_reg;
    logic [FW-1:0] idx_reg;
    logic          pend_reg;
    logic          first_reg;
    logic signed [31:0] lo_reg, hi_reg;
    logic [61:0]   prod_reg;
    logic          qbad;
    logic          ring_re;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   rdata;
    logic [31:0]   lo_abs;

    assign qbad    = (5'(in_qs) >= 5'(MAX_SENSORS));
    assign ring_re = cmd.walk && (idx_reg < qfill_reg);
    assign waddr   = AW'(AW'(cur_i) * AW'(RING_POINTS) + AW'(head_reg[cur_i]));
    assign raddr   = AW'(AW'(qs_reg) * AW'(RING_POINTS) + AW'(idx_reg));
    assign st.walk_done = (idx_reg == qfill_reg) && !pend_reg;
    assign lo_abs  = lo_reg[31] ? (32'd0 - lo_reg) : lo_reg;

    dfpr_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (waddr),
        .wdata (val),
        .re    (ring_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            pend_reg <= 1'b0;
        end
        else if (cmd.walk)
        begin
            pend_reg <= ring_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            qs_reg    <= SW'(in_qs);
            qid_reg   <= in_qs;
            qfill_reg <= qbad ? '0 : fill_reg[SW'(in_qs)];
            idx_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.walk)
        begin
            if (ring_re)
            begin
                idx_reg <= idx_reg + FW'(1);
            end
            if (pend_reg)
            begin
                first_reg <= 1'b0;
                if (first_reg || ($signed(rdata) < lo_reg))
                begin
                    lo_reg <= $signed(rdata);
                end
                if (first_reg || ($signed(rdata) > hi_reg))
                begin
                    hi_reg <= $signed(rdata);
                end
            end
        end
        if (cmd.qdiv)
        begin
            prod_reg <= 62'(lo_abs[31:2]) * 62'(RECIP_FIVE);
        end
    end

    // Flat ring: widen by a twentieth of the value, at least one hundredth; a zero value widens by one.
    logic [27:0] q20;
    logic [31:0] margin;
    logic        flat;
    logic signed [31:0] rlo, rhi;

    assign q20    = prod_reg[61:34];
    assign flat   = (lo_reg == hi_reg);
    assign margin = (lo_reg == 32'sd0) ? FLAT_MARGIN
                  : ((q20 == 28'd0) ? 32'd1 : 32'(q20));
    assign rlo    = flat ? (lo_reg - $signed(margin)) : lo_reg;
    assign rhi    = flat ? (hi_reg + $signed(margin)) : hi_reg;

    // Output register.
    logic         ovalid_reg;
    logic [103:0] odata_reg;
    logic         ouser_reg;
    logic         olast_reg;
    logic         last_close;

    assign st.out_free = !ovalid_reg || m_tready;
    assign last_close  = !(((cur_reg + CW'(1)) < active) && cmd.more);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if ((cmd.close && st.cur_lt_active) || cmd.qout)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.close && st.cur_lt_active)
        begin
            ouser_reg <= 1'b0;
            olast_reg <= last_close;
            odata_reg <= {((cur_reg + CW'(1)) == active) ? 4'(good_next) : 4'd0,
                          32'd0, 32'd0,
                          field_ok ? val : 32'd0,
                          field_ok, 3'(cur_reg)};
        end
        else if (cmd.qout)
        begin
            ouser_reg <= 1'b1;
            olast_reg <= 1'b1;
            if (qfill_reg == '0)
            begin
                odata_reg <= {4'd0, 32'd0, 32'd0, 32'd0, 1'b0, qid_reg};
            end
            else
            begin
                odata_reg <= {4'd0, rhi, rlo, 32'd0, 1'b1, qid_reg};
            end
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

endmodule

[hw/rtl/decimal_field_parser_with_rings_core.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  tdata: char_byte, query_sensor; tuser: operation;
//                                          tlast: final_byte
// m_*      out        m_tvalid / m_tready  tdata: sensor_id, valid_res, value_centi, range_low,
//                                          range_high, good_count; tuser: report_kind;
//                                          tlast: last_of_run
// cfg_*    in         cfg_valid / cfg_ready  cfg_data: sensor_count
//
// A response byte that closes no field is taken in idle and leaves the controller in idle,
// ready for the next byte. A byte that closes fields sends the controller to its close loop,
// which closes one field at a time, waiting for room in the output register for each field
// it reports, and then returns to idle. A range query walks the ring one entry per cycle
// through the ring memory's read port, then forms the margin product and loads the report.
// Reset clears all control state and the per-sensor ring heads and fill counts; the ring
// memory itself is never cleared, as only written entries are read. A stalled output
// register holds its report and holds off only the next report, not bytes that make none.

module decimal_field_parser_with_rings_core #(
    parameter int MAX_SENSORS    = 8,
    parameter int RING_POINTS    = 64,
    parameter int RESPONSE_BYTES = 1024,
    parameter int FIELD_CHARS    = 39
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [7:0] char_byte, [10:8] query_sensor, rest zero
    input  logic         s_tuser,   // [0] operation
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [2:0] sensor_id, [3] valid_res, [35:4] value_centi,
                                    // [67:36] range_low, [99:68] range_high,
                                    // [103:100] good_count
    output logic         m_tuser,   // [0] report_kind
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_data
);

    import dfpr_pkg::*;

    dfpr_cmd_t cmd;
    dfpr_st_t  st;

    // The sensor count register accepts a request in every cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences the field closes and the ring walk; the
    // datapath holds the parser, ring pointers, ring memory and output register.
    dfpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dfpr_dp #(
        .MAX_SENSORS    (MAX_SENSORS),
        .RING_POINTS    (RING_POINTS),
        .RESPONSE_BYTES (RESPONSE_BYTES),
        .FIELD_CHARS    (FIELD_CHARS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import dfpr_pkg::*;

    localparam int RING_LEN   = 64;
    localparam int NSENS      = 8;
    localparam int MAX_BYTES  = 1024;
    localparam int FIELD_LEN  = 39;
    localparam int CYCLE_LIMIT = 400000;

    // One input request as the byte stream carries it.
    typedef struct {
        bit       op;
        bit [7:0] ch;
        bit       fin;
        bit [2:0] qs;
    } req_t;

    // One report the block is expected to send.
    typedef struct {
        bit       kind;
        bit [2:0] id;
        bit       vld;
        int       val;
        int       lo;
        int       hi;
        bit [3:0] good;
        bit       last;
    } report_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;
    logic         s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [3:0]   cfg_data;

    decimal_field_parser_with_rings_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Requests waiting to be sent and reports waiting to arrive.
    req_t    pending_reqs[$];
    report_t expected_reports[$];
    int      errors;
    int      cycles;
    int      idle_pct;
    int      stall_pct;
    int      hold_cycles;
    bit      offering;

    // Shadow copy of the parser state and the rings.
    int       sensor_cnt;
    phase_t   phase;
    bit       neg;
    int       int_acc;
    int       frac_acc;
    int       frac_digits;
    int       chars_in_field;
    int       cur_sensor;
    int       good_cnt;
    bit       ended;
    int       bytes_seen;
    int       ring_vals[NSENS * RING_LEN];
    int       ring_head[NSENS];
    int       ring_fill[NSENS];

    function automatic int active_sensors();
        return (sensor_cnt > NSENS) ? NSENS : sensor_cnt;
    endfunction

    task automatic clear_field();
        phase = PH_LEAD;
        neg = 1'b0;
        int_acc = 0;
        frac_acc = 0;
        frac_digits = 0;
        chars_in_field = 0;
    endtask

    task automatic clear_response();
        clear_field();
        cur_sensor = 0;
        good_cnt = 0;
        ended = 1'b0;
        bytes_seen = 0;
    endtask

    task automatic push_report(bit kind, int id, bit vld, int val, int lo, int hi, int good);
        report_t r;
        r.kind = kind;
        r.id = id[2:0];
        r.vld = vld;
        r.val = val;
        r.lo = lo;
        r.hi = hi;
        r.good = good[3:0];
        r.last = 1'b0;
        expected_reports.push_back(r);
    endtask

    // Advances the field parser by one character.
    task automatic parse_char(bit [7:0] c);
        bit     is_digit;
        int     d;
        longint a;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d = int'(c) - int'(CHAR_ZERO);
        case (phase)
            PH_LEAD:
            begin
                if (c == CHAR_MINUS)
                begin
                    neg = 1'b1;
                    phase = PH_SIGNED;
                end
                else if (c == CHAR_PLUS)
                    phase = PH_SIGNED;
                else if (is_digit)
                begin
                    int_acc = d;
                    phase = PH_INT;
                end
                else if (c != CHAR_SPACE)
                    phase = PH_BAD;
            end
            PH_SIGNED:
            begin
                if (is_digit)
                begin
                    int_acc = d;
                    phase = PH_INT;
                end
                else
                    phase = PH_BAD;
            end
            PH_INT:
            begin
                if (is_digit)
                begin
                    a = longint'(int_acc) * 10 + d;
                    if (a > 20000000)
                        phase = PH_BAD;
                    else
                        int_acc = int'(a);
                end
                else if (c == CHAR_DOT)
                    phase = PH_FRAC;
                else
                    phase = PH_DONE;
            end
            PH_FRAC:
            begin
                if (is_digit)
                begin
                    frac_acc = frac_acc * 10 + d;
                    frac_digits++;
                    if (frac_digits >= 2)
                        phase = PH_DONE;
                end
                else
                    phase = PH_DONE;
            end
            default:
            begin
            end
        endcase
    endtask

    // Closes the current field: for a sensor in use, reports it and, if good, stores it in the ring.
    task automatic close_field();
        int n;
        int s;
        bit ok;
        int v;
        n = active_sensors();
        if (cur_sensor < n)
        begin
            s = cur_sensor;
            ok = (phase == PH_INT) || (phase == PH_FRAC) || (phase == PH_DONE);
            v = 0;
            if (ok)
            begin
                v = int_acc * 100 + ((frac_digits == 1) ? frac_acc * 10 : frac_acc);
                if (neg)
                    v = -v;
                ring_vals[s * RING_LEN + ring_head[s]] = v;
                ring_head[s] = (ring_head[s] + 1) % RING_LEN;
                if (ring_fill[s] < RING_LEN)
                    ring_fill[s]++;
                good_cnt++;
            end
            push_report(1'b0, s, ok, v, 0, 0, (s + 1 == n) ? good_cnt : 0);
        end
        if (cur_sensor < NSENS)
            cur_sensor++;
        clear_field();
    endtask

    task automatic end_content();
        close_field();
        while (cur_sensor < active_sensors())
            close_field();
        ended = 1'b1;
    endtask

    // Works out the reports that one accepted request causes.
    task automatic predict_reports(req_t q);
        int     prior_size;
        int     s;
        longint lo;
        longint hi;
        longint m;
        prior_size = expected_reports.size();
        if (q.op)
        begin
            s = q.qs;
            if (ring_fill[s] == 0)
                push_report(1'b1, s, 1'b0, 0, 0, 0, 0);
            else
            begin
                lo = ring_vals[s * RING_LEN];
                hi = lo;
                for (int i = 0; i < ring_fill[s]; i++)
                begin
                    if (ring_vals[s * RING_LEN + i] < lo)
                        lo = ring_vals[s * RING_LEN + i];
                    if (ring_vals[s * RING_LEN + i] > hi)
                        hi = ring_vals[s * RING_LEN + i];
                end
                if (lo == hi)
                begin
                    m = (lo == 0) ? 100 : ((lo > 0) ? lo / 20 : -lo / 20);
                    if (m < 1)
                        m = 1;
                    lo -= m;
                    hi += m;
                end
                push_report(1'b1, s, 1'b1, 0, int'(lo), int'(hi), 0);
            end
        end
        else
        begin
            if (!ended)
            begin
                if (q.ch == 8'd0 || bytes_seen >= MAX_BYTES - 1)
                    end_content();
                else
                begin
                    bytes_seen++;
                    if (q.ch == CHAR_PIPE)
                        close_field();
                    else if (cur_sensor < active_sensors() && chars_in_field < FIELD_LEN)
                    begin
                        parse_char(q.ch);
                        chars_in_field++;
                    end
                end
            end
            if (q.fin)
            begin
                if (!ended)
                    end_content();
                clear_response();
            end
        end
        if (expected_reports.size() > prior_size)
            expected_reports[expected_reports.size() - 1].last = 1'b1;
    endtask

    // Accepts requests and checks reports at the rising edge.
    always @(posedge clk)
    begin
        report_t  e;
        bit [2:0] id;
        bit       vld;
        int       val;
        int       lo;
        int       hi;
        bit [3:0] good;
        if (rst_n && m_tvalid && m_tready)
        begin
            id = m_tdata[2:0];
            vld = m_tdata[3];
            val = m_tdata[35:4];
            lo = m_tdata[67:36];
            hi = m_tdata[99:68];
            good = m_tdata[103:100];
            if (expected_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report: kind %0d sensor %0d", m_tuser, id);
            end
            else
            begin
                e = expected_reports.pop_front();
                if (e.kind != m_tuser || e.id != id || e.vld != vld || e.val != val
                    || e.lo != lo || e.hi != hi || e.good != good || e.last != m_tlast)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display({"mismatch: exp kind %0d id %0d ok %0d val %0d ",
                                  "rng %0d..%0d good %0d last %0d"},
                                 e.kind, e.id, e.vld, e.val, e.lo, e.hi, e.good, e.last);
                        $display({"          got kind %0d id %0d ok %0d val %0d ",
                                  "rng %0d..%0d good %0d last %0d"},
                                 m_tuser, id, vld, val, lo, hi, good, m_tlast);
                    end
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_reports(pending_reqs.pop_front());
            offering = 1'b0;
        end
    end

    // Request driver: offers the head of the queue at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && !offering && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            offering = 1'b1;
            s_tdata <= {5'd0, pending_reqs[0].qs, pending_reqs[0].ch};
            s_tuser <= pending_reqs[0].op;
            s_tlast <= pending_reqs[0].fin;
        end
        s_tvalid <= offering;
    end

    // Report receiver: random stalls, plus a long hold-off when asked.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_req(bit op, bit [7:0] ch, bit fin, bit [2:0] qs);
        req_t q;
        q.op = op;
        q.ch = ch;
        q.fin = fin;
        q.qs = qs;
        pending_reqs.push_back(q);
    endtask

    task automatic add_text(string t);
        for (int i = 0; i < t.len(); i++)
            add_req(1'b0, t[i], 1'b0, 3'($urandom));
    endtask

    // Builds one field: mostly well-formed numbers with random content.
    function automatic string make_field();
        string f;
        int    pick;
        f = "";
        pick = $urandom_range(19);
        if (pick == 0)
        begin
            for (int i = 0; i < $urandom_range(3); i++)
                f = {f, string'(byte'($urandom_range(1, 255)))};
            return f;
        end
        if (pick == 1)
        begin
            for (int i = 0; i < 40; i++)
                f = {f, " "};
            return {f, "5"};
        end
        for (int i = 0; i < $urandom_range(0, 2); i++)
            f = {f, " "};
        case ($urandom_range(3))
            0: f = {f, "-"};
            1: f = {f, "+"};
            default:
            begin
            end
        endcase
        case ($urandom_range(5))
            0: f = {f, "20000000"};
            1: f = {f, "20000001"};
            2: f = {f, $sformatf("%0d", $urandom_range(20000000))};
            3: f = {f, ""};
            default: f = {f, $sformatf("%0d", $urandom_range(999))};
        endcase
        case ($urandom_range(4))
            0: f = {f, "."};
            1: f = {f, ".", $sformatf("%0d", $urandom_range(9))};
            2: f = {f, ".", $sformatf("%0d%0d", $urandom_range(9), $urandom_range(9))};
            3: f = {f, ".", $sformatf("%0d", $urandom_range(100, 999))};
            default:
            begin
            end
        endcase
        if ($urandom_range(7) == 0)
            f = {f, "x7"};
        return f;
    endfunction

    // One response: fields split by the separator, ended in one of several ways.
    task automatic add_response();
        int nf;
        nf = $urandom_range(0, 6);
        for (int i = 0; i < nf; i++)
        begin
            add_text(make_field());
            if (i < nf - 1 || $urandom_range(1) == 0)
                add_req(1'b0, CHAR_PIPE, 1'b0, 3'($urandom));
        end
        case ($urandom_range(3))
            0: add_req(1'b0, 8'd0, 1'b1, 3'($urandom));
            1:
            begin
                add_req(1'b0, 8'd0, 1'b0, 3'($urandom));
                add_text("12|3");
                add_req(1'b0, 8'($urandom_range(1, 255)), 1'b1, 3'($urandom));
            end
            default:
            begin
                if (pending_reqs.size() > 0 && !pending_reqs[$].fin && !pending_reqs[$].op)
                    pending_reqs[pending_reqs.size() - 1].fin = 1'b1;
                else
                    add_req(1'b0, CHAR_SPACE, 1'b1, 3'($urandom));
            end
        endcase
    endtask

    task automatic write_count(bit [3:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sensor_cnt = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_reports.size() == 0);
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        int counts[6];
        counts = '{8, 1, 0, 15, 3, 5};
        errors = 0;
        cycles = 0;
        offering = 1'b0;
        hold_cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b1;
        cfg_valid = 1'b0;
        cfg_data = '0;
        sensor_cnt = 8;
        clear_response();
        for (int s = 0; s < NSENS; s++)
        begin
            ring_head[s] = 0;
            ring_fill[s] = 0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: an empty ring, the upper range extreme, sign forms, a bad field,
        // and more fields than there are sensors.
        add_req(1'b1, 8'd0, 1'b0, 3'd7);
        add_text("20000000.99|-0.5|+7|a|1|2|3|4|5|6|");
        add_req(1'b0, 8'd0, 1'b1, 3'd0);
        add_req(1'b1, 8'hFF, 1'b1, 3'd0);
        add_req(1'b1, 8'd0, 1'b0, 3'd2);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_count(counts[p]);
            idle_pct = (p % 4 == 1) ? 53 : ((p % 4 == 3) ? 6 : 0);
            stall_pct = (p % 4 == 2) ? 53 : ((p % 4 == 3) ? 6 : 0);
            if (p == 1)
                hold_cycles = 300;
            while (pending_reqs.size() < 25)
            begin
                add_response();
                for (int i = 0; i < $urandom_range(0, 2); i++)
                    add_req(1'b1, 8'($urandom), 1'($urandom), 3'($urandom));
            end
            // A partial response left open across the next count change.
            if (p == 2)
                add_text("1|2");
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
